### src/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg: shared types, codes and pixel classification helpers
// Register codes, depth codes, color codes and the per-pixel tests used by
// the palette load path and the direct-color decode path.
// ----------------------------------------------------------------------------
package btp_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 1024;
  localparam int DEF_PALETTE_ENTRIES = 256;

  // port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int COORD_W     = 10;
  localparam int BYTES_W     = 12;

  // palette entry layout
  localparam int PAL_BITS  = 2;
  localparam int PAL_WHITE = 1;
  localparam int PAL_RED   = 0;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FMT565    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_UP = 3'd6;

  // depth codes (5 to 7 decode as 24 bit)
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_4  = 3'd1;
  localparam logic [2:0] DEPTH_8  = 3'd2;
  localparam logic [2:0] DEPTH_16 = 3'd3;
  localparam logic [2:0] DEPTH_24 = 3'd4;

  // item kinds
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_PIXEL   = 1'b1;

  // classification thresholds
  localparam logic [7:0] WHITE_LEVEL = 8'h80;
  localparam logic [7:0] COLOR_LEVEL = 8'hF0;
  localparam logic [9:0] WHITE_SUM   = 10'd384;

  typedef enum logic [1:0] {
    COLOR_BLACK = 2'd0,
    COLOR_WHITE = 2'd1,
    COLOR_RED   = 2'd2
  } color_t;

  typedef struct packed {
    logic [2:0]  depth_sel;
    logic        format_565;
    logic        red_enable;
    logic [10:0] width_pixels;
    logic [11:0] row_bytes;
    logic [10:0] rows_in_use;
    logic        bottom_up;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    depth_sel:    DEPTH_24,
    format_565:   1'b0,
    red_enable:   1'b0,
    width_pixels: 11'd1,
    row_bytes:    12'd4,
    rows_in_use:  11'd1,
    bottom_up:    1'b1
  };

  // one pixel on its way from the unpack stage to the output stage
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               use_pal;
    logic               idx_ok;
    logic               white;
    logic               red;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } pix_meta_t;

  function automatic logic is_whitish(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic color_on);
    logic [9:0] sum;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    if (color_on) begin
      return (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
    end
    return sum > WHITE_SUM;
  endfunction

  function automatic logic is_colored(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
  endfunction

  function automatic color_t pick_color(input logic white, input logic red,
                                        input logic color_on);
    if (white) begin
      return COLOR_WHITE;
    end
    if (red && color_on) begin
      return COLOR_RED;
    end
    return COLOR_BLACK;
  endfunction

endpackage

### src/bmp_to_tricolor_pixel_stream_top.sv
// ----------------------------------------------------------------------------
// bmp_to_tricolor_pixel_stream_top: BMP row bytes to three-color pixels
// Decodes BMP pixel data and classifies each pixel as black, white or red.
// ----------------------------------------------------------------------------
// Items on the input channel are either palette entries (in_func = 0) or raw
// bytes of the stored BMP rows, padding included (in_func = 1). A data byte
// at 1-bit depth is stepped through as eight pixels in the unpack stage, at
// 4-bit depth as two, and as one at 8, 16 and 24 bit; a palette entry is one
// step. The palette memory has one read port and so looks up one pixel per
// cycle while the output is not stalled and the remainder unit is idle. A
// result passes the unpack stage, the palette read and the output register.
// Writing rows_in_use starts a bit-serial remainder of the row counter that
// holds off item processing until the remainder has finished.
// Palette entries must be loaded before a pixel refers to them; the palette
// is not cleared after reset. Configuration must be written while idle.
// ----------------------------------------------------------------------------
module bmp_to_tricolor_pixel_stream_top #(
  parameter int MAX_WIDTH       = btp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = btp_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = btp_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [btp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [btp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [7:0]                       in_palette_index,
  input  logic [7:0]                       in_red_level,
  input  logic [7:0]                       in_green_level,
  input  logic [7:0]                       in_blue_level,
  input  logic [7:0]                       in_data_byte,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_pixel_color,
  output logic [btp_pkg::COORD_W-1:0]      out_pixel_column,
  output logic [btp_pkg::COORD_W-1:0]      out_pixel_row,
  output logic                             out_last
);

  import btp_pkg::*;

  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(PALETTE_ENTRIES);

  cfg_t cfg_r;
  logic rows_wr_r;   // row total just changed, restart the remainder
  logic color_on;

  // unpack to memory, remainder unit and output stage
  logic                en;
  logic                rm_busy;
  logic [RW-1:0]       row_mod, rows_eff, row_count, row_set_val;
  logic                row_set;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [PAL_BITS-1:0] ram_wdata, ram_rdata;
  pix_meta_t           meta;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_RESET;
      rows_wr_r <= 1'b0;
    end else begin
      rows_wr_r <= cfg_we && (cfg_index == CFG_ROWS);
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPTH:     cfg_r.depth_sel    <= cfg_data[2:0];
          CFG_FMT565:    cfg_r.format_565   <= cfg_data[0];
          CFG_COLOR:     cfg_r.red_enable   <= cfg_data[0];
          CFG_WIDTH:     cfg_r.width_pixels <= cfg_data[10:0];
          CFG_ROW_BYTES: cfg_r.row_bytes    <= cfg_data[11:0];
          CFG_ROWS:      cfg_r.rows_in_use  <= cfg_data[10:0];
          CFG_BOTTOM_UP: cfg_r.bottom_up    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // red output and per-channel white test only apply above 1-bit depth
  assign color_on = cfg_r.red_enable && (cfg_r.depth_sel != DEPTH_1);

  // input register, pixel stepping and row position
  btp_unpack #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_unpack (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .color_on         (color_on),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_palette_index (in_palette_index),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .in_data_byte     (in_data_byte),
    .en               (en),
    .rm_busy          (rm_busy),
    .row_mod          (row_mod),
    .rows_eff         (rows_eff),
    .row_count        (row_count),
    .row_set_val      (row_set_val),
    .row_set          (row_set),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .meta             (meta)
  );

  // palette: whitish and colored bit per entry, computed at load time
  btp_ram #(
    .WIDTH (PAL_BITS),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // row counter modulo row total, used by the bottom-up flip
  btp_rowmod #(
    .W (RW)
  ) u_rowmod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rows_wr_r),
    .set      (row_set),
    .set_val  (row_set_val),
    .dividend (row_count),
    .divisor  (rows_eff),
    .busy     (rm_busy),
    .rem      (row_mod)
  );

  // palette merge, color pick and output register
  btp_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .meta             (meta),
    .pal_bits         (ram_rdata),
    .color_on         (color_on),
    .en               (en),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pixel_color  (out_pixel_color),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_last         (out_last)
  );

  // flipped row must stay inside the image once the remainder has settled
  a_row_mod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !rm_busy |-> (row_mod < rows_eff))
    else $error("row remainder not below row total");

  // a palette load and a pixel lookup never share a cycle
  a_palette_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("palette write and read in the same cycle");

  // no result item straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

### src/btp_ram.sv
// ----------------------------------------------------------------------------
// btp_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module btp_ram #(
  parameter int WIDTH = btp_pkg::PAL_BITS,
  parameter int DEPTH = btp_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/btp_rowmod.sv
// ----------------------------------------------------------------------------
// btp_rowmod: row counter remainder unit
// Holds row_count modulo the row total; recomputed bit-serially by a
// restoring remainder loop after the row total changes.
// ----------------------------------------------------------------------------
module btp_rowmod #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         set,
  input  logic [W-1:0] set_val,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] rem
);

  localparam int IW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic [IW-1:0] bit_r, bit_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W:0]    trial;

  always_comb begin
    trial    = {acc_r, dividend[bit_r]};
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = IW'(W - 1);
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        acc_nxt = W'(trial - {1'b0, divisor});
      end else begin
        acc_nxt = trial[W-1:0];
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        rem_nxt  = acc_nxt;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end else if (set) begin
      rem_nxt = set_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
      acc_r  <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy = busy_r | start;
  assign rem  = rem_r;

endmodule

### src/btp_unpack.sv
// ----------------------------------------------------------------------------
// btp_unpack: input register and byte unpacking stage
// Holds one item, steps its pixels one per cycle unless stalled, tracks row
// position, assembles 16/24-bit pixels and issues palette reads and writes.
// ----------------------------------------------------------------------------
module btp_unpack #(
  parameter int MAX_WIDTH       = btp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = btp_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = btp_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  btp_pkg::cfg_t                      cfg,
  input  logic                               color_on,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [7:0]                         in_palette_index,
  input  logic [7:0]                         in_red_level,
  input  logic [7:0]                         in_green_level,
  input  logic [7:0]                         in_blue_level,
  input  logic [7:0]                         in_data_byte,
  input  logic                               en,
  input  logic                               rm_busy,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    row_mod,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]    rows_eff,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]    row_count,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]    row_set_val,
  output logic                               row_set,
  output logic                               ram_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
  output logic [btp_pkg::PAL_BITS-1:0]       ram_wdata,
  output logic                               ram_re,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr,
  output btp_pkg::pix_meta_t                 meta
);

  import btp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(PALETTE_ENTRIES);

  // held item
  logic       a_valid_r, a_valid_nxt;
  logic       a_func_r;
  logic [7:0] a_idx_r, a_red_r, a_grn_r, a_blu_r, a_byte_r;
  logic [2:0] k_r, k_nxt;

  // row position
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [BYTES_W-1:0] bir_r, bir_nxt;
  logic [15:0]        part_r, part_nxt;
  logic [1:0]         phase_r, phase_nxt;

  logic [CW-1:0]      width_eff;
  logic [BYTES_W-1:0] rb, bir_inc;
  logic [RW-1:0]      row_inc, row_sel;
  logic               step, is_pix, indexed, last_step, emit, col_ok, col_last;
  logic [2:0]         kmax;
  logic [7:0]         pix_idx, lo, hi, rgb_r, rgb_g, rgb_b;
  logic               rgb_done;
  logic [15:0]        rgb_part;
  logic [1:0]         rgb_phase;

  always_comb begin
    // effective geometry
    if (int'(cfg.width_pixels) > MAX_WIDTH) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(cfg.width_pixels);
    end
    if (int'(cfg.rows_in_use) > MAX_HEIGHT) begin
      rows_eff = RW'(MAX_HEIGHT);
    end else if (cfg.rows_in_use == '0) begin
      rows_eff = RW'(1);
    end else begin
      rows_eff = RW'(cfg.rows_in_use);
    end
    rb = (cfg.row_bytes == '0) ? BYTES_W'(1) : cfg.row_bytes;

    step    = a_valid_r && en && !rm_busy;
    is_pix  = (a_func_r == FUNC_PIXEL);
    indexed = cfg.depth_sel inside {DEPTH_1, DEPTH_4, DEPTH_8};

    // indexed pixel select, msb first
    case (cfg.depth_sel)
      DEPTH_1: begin
        kmax    = 3'd7;
        pix_idx = {7'd0, a_byte_r[~k_r]};
      end
      DEPTH_4: begin
        kmax    = 3'd1;
        pix_idx = k_r[0] ? {4'd0, a_byte_r[3:0]} : {4'd0, a_byte_r[7:4]};
      end
      default: begin
        kmax    = 3'd0;
        pix_idx = a_byte_r;
      end
    endcase

    // direct color assembly
    lo = part_r[7:0];
    hi = a_byte_r;
    if (cfg.depth_sel == DEPTH_16) begin
      rgb_b = {lo[4:0], 3'b000};
      if (cfg.format_565) begin
        rgb_g = {hi[2:0], lo[7:5], 2'b00};
        rgb_r = {hi[7:3], 3'b000};
      end else begin
        rgb_g = {hi[1:0], lo[7:5], 3'b000};
        rgb_r = {hi[6:2], 3'b000};
      end
      rgb_done = (phase_r != 2'd0);
      if (phase_r == 2'd0) begin
        rgb_part  = {8'd0, a_byte_r};
        rgb_phase = 2'd1;
      end else begin
        rgb_part  = '0;
        rgb_phase = 2'd0;
      end
    end else begin
      rgb_r    = a_byte_r;
      rgb_g    = part_r[15:8];
      rgb_b    = part_r[7:0];
      rgb_done = (phase_r != 2'd0) && (phase_r != 2'd1);
      if (phase_r == 2'd0) begin
        rgb_part  = {8'd0, a_byte_r};
        rgb_phase = 2'd1;
      end else if (phase_r == 2'd1) begin
        rgb_part  = part_r | {a_byte_r, 8'd0};
        rgb_phase = 2'd2;
      end else begin
        rgb_part  = '0;
        rgb_phase = 2'd0;
      end
    end

    last_step = !is_pix || !indexed || (k_r == kmax);
    col_ok    = col_r < width_eff;
    col_last  = ({1'b0, col_r} + 1'b1) >= {1'b0, width_eff};
    emit      = is_pix && col_ok && (indexed || rgb_done);

    row_sel = cfg.bottom_up ? (rows_eff - RW'(1) - row_mod) : row_r;
    row_inc = row_r + RW'(1);
    bir_inc = bir_r + BYTES_W'(1);

    meta.valid   = step && emit;
    meta.last    = indexed ? ((k_r == kmax) || col_last) : 1'b1;
    meta.use_pal = indexed;
    meta.idx_ok  = {24'd0, pix_idx} < 32'(PALETTE_ENTRIES);
    meta.white   = is_whitish(rgb_r, rgb_g, rgb_b, color_on);
    meta.red     = is_colored(rgb_r, rgb_g, rgb_b);
    meta.column  = COORD_W'(col_r);
    meta.row     = COORD_W'(row_sel);

    // palette port
    ram_re    = step && is_pix && indexed;
    ram_raddr = AW'(pix_idx);
    ram_we    = step && !is_pix && ({24'd0, a_idx_r} < 32'(PALETTE_ENTRIES));
    ram_waddr = AW'(a_idx_r);
    ram_wdata[PAL_WHITE] = is_whitish(a_red_r, a_grn_r, a_blu_r, color_on);
    ram_wdata[PAL_RED]   = is_colored(a_red_r, a_grn_r, a_blu_r);

    in_ready = !a_valid_r || (step && last_step);

    // next state
    a_valid_nxt = a_valid_r;
    k_nxt       = k_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    bir_nxt     = bir_r;
    part_nxt    = part_r;
    phase_nxt   = phase_r;
    row_set     = 1'b0;
    if (step) begin
      if (!last_step) begin
        k_nxt   = k_r + 3'd1;
        col_nxt = col_r + CW'(emit);
      end else begin
        k_nxt       = '0;
        a_valid_nxt = 1'b0;
        if (is_pix) begin
          if (bir_inc >= rb) begin
            // end of stored row
            bir_nxt   = '0;
            col_nxt   = '0;
            part_nxt  = '0;
            phase_nxt = '0;
            row_set   = 1'b1;
            row_nxt   = (row_inc >= rows_eff) ? '0 : row_inc;
          end else begin
            bir_nxt = bir_inc;
            col_nxt = col_r + CW'(emit);
            if (!indexed) begin
              part_nxt  = rgb_part;
              phase_nxt = rgb_phase;
            end
          end
        end
      end
    end
    if (in_valid && in_ready) begin
      a_valid_nxt = 1'b1;
      k_nxt       = '0;
    end

    row_count   = row_r;
    row_set_val = row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      k_r       <= '0;
      col_r     <= '0;
      row_r     <= '0;
      bir_r     <= '0;
      part_r    <= '0;
      phase_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      k_r       <= k_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      bir_r     <= bir_nxt;
      part_r    <= part_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_func_r <= in_func;
      a_idx_r  <= in_palette_index;
      a_red_r  <= in_red_level;
      a_grn_r  <= in_green_level;
      a_blu_r  <= in_blue_level;
      a_byte_r <= in_data_byte;
    end
  end

endmodule

### src/btp_emit.sv
// ----------------------------------------------------------------------------
// btp_emit: palette read stage and output register
// Merges the palette bits with the pixel position, picks the color code and
// holds the result item until the consumer takes it.
// ----------------------------------------------------------------------------
module btp_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btp_pkg::pix_meta_t            meta,
  input  logic [btp_pkg::PAL_BITS-1:0]  pal_bits,
  input  logic                          color_on,
  output logic                          en,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_pixel_color,
  output logic [btp_pkg::COORD_W-1:0]   out_pixel_column,
  output logic [btp_pkg::COORD_W-1:0]   out_pixel_row,
  output logic                          out_last
);

  import btp_pkg::*;

  pix_meta_t          b_r;
  logic               out_valid_r;
  color_t             color_r;
  logic [COORD_W-1:0] column_r, row_r;
  logic               last_r;
  logic               white, red;
  color_t             color_nxt;

  assign en = !out_valid_r || out_ready;

  always_comb begin
    if (b_r.use_pal) begin
      white = b_r.idx_ok & pal_bits[PAL_WHITE];
      red   = b_r.idx_ok & pal_bits[PAL_RED];
    end else begin
      white = b_r.white;
      red   = b_r.red;
    end
    color_nxt = pick_color(white, red, color_on);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_r         <= meta;
      out_valid_r <= b_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_r  <= color_nxt;
      column_r <= b_r.column;
      row_r    <= b_r.row;
      last_r   <= b_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_color  = color_r;
  assign out_pixel_column = column_r;
  assign out_pixel_row    = row_r;
  assign out_last         = last_r;

endmodule
